@@ rtl/pnm_pkg.sv @@
// Package for the propensity nearest-match block.
// Holds the request and result structs, the group codes and the types that
// travel along the chain of matching cells. Depends on nothing.
package pnm_pkg;

    localparam int SCORE_W_MAX = 32;
    localparam int IDX_W       = 6;

    localparam logic [1:0] GRP_CONTROL = 2'd0;
    localparam logic [1:0] GRP_TREATED = 2'd1;

    typedef struct packed {
        logic [15:0] score;
        logic [1:0]  group;
        logic        last_sample;
    } t_sample;

    typedef struct packed {
        logic [IDX_W-1:0] treated_index;
        logic [IDX_W-1:0] control_index;
        logic             pair_valid;
        logic [IDX_W-1:0] pair_count;
        logic             end_of_run;
        logic             overflow;
    } t_result;

    // One stored sample on its way along the feed line.
    typedef struct packed {
        logic [SCORE_W_MAX-1:0] score;
        logic [1:0]             group;
    } t_feed;

    // One treated query and its best control so far.
    typedef struct packed {
        logic [SCORE_W_MAX-1:0] score;
        logic [IDX_W-1:0]       treated_index;
        logic                   valid;
        logic                   found;
        logic [SCORE_W_MAX-1:0] best_gap;
        logic [IDX_W-1:0]       best_index;
    } t_query;

endpackage

@@ rtl/pnm_cell.sv @@
// One cell of the matching chain: stores one sample, passes the feed line
// toward cell zero and refines the passing query against its own sample.
// Depends on pnm_pkg.
module pnm_cell #(
    parameter int SCORE_BITS = 16,
    parameter int CNT_W      = 7,
    parameter int CELL_IDX   = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [SCORE_BITS-1:0] i_wr_score,
    input  logic [1:0]           i_wr_group,
    input  logic                 i_feed_load,
    input  logic                 i_feed_shift,
    input  pnm_pkg::t_feed       i_feed_next,
    output pnm_pkg::t_feed       o_feed,
    input  logic [CNT_W-1:0]     i_count,
    input  pnm_pkg::t_query      i_query,
    output pnm_pkg::t_query      o_query
);
    import pnm_pkg::*;

    logic [SCORE_BITS-1:0] r_score;
    logic [1:0]            r_group;
    t_feed                 r_feed;
    t_query                r_query;
    t_query                n_query;
    logic [SCORE_BITS-1:0] w_qscore;
    logic [SCORE_BITS-1:0] w_dist;
    logic                  w_active;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_score <= i_wr_score;
            r_group <= i_wr_group;
        end
        if (i_feed_load) begin
            r_feed.score <= SCORE_W_MAX'(r_score);
            r_feed.group <= r_group;
        end else if (i_feed_shift) begin
            r_feed <= i_feed_next;
        end
    end

    assign o_feed   = r_feed;
    assign w_qscore = i_query.score[SCORE_BITS-1:0];
    assign w_dist   = (w_qscore >= r_score) ? (w_qscore - r_score) : (r_score - w_qscore);
    // Only occupied cells holding a control sample take part.
    assign w_active = (CNT_W'(CELL_IDX) < i_count) && (r_group == GRP_CONTROL);

    always_comb begin
        n_query = i_query;
        // Strict less-than keeps the lowest index on a tie.
        if (i_query.valid && w_active &&
            (!i_query.found || (w_dist < i_query.best_gap[SCORE_BITS-1:0]))) begin
            n_query.found      = 1'b1;
            n_query.best_gap   = SCORE_W_MAX'(w_dist);
            n_query.best_index = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query.valid <= 1'b0;
        end else begin
            r_query.valid <= n_query.valid;
        end
        r_query.score         <= n_query.score;
        r_query.treated_index <= n_query.treated_index;
        r_query.found         <= n_query.found;
        r_query.best_gap      <= n_query.best_gap;
        r_query.best_index    <= n_query.best_index;
    end

    assign o_query = r_query;

endmodule

@@ rtl/propensity_nearest_match.sv @@
// Top level of the propensity nearest-match block.
// Instantiates a row of pnm_cell and runs loading, matching and result output.
// Depends on pnm_pkg and pnm_cell.
//
//   channel   direction  handshake                    payload
//   request   in         start high while busy low    i_sample (t_sample)
//   result    out        o_strobe high for one cycle  o_result (t_result)
//
// A request that is not the last sample of a set is stored in the cell whose
// index equals the running sample count; busy stays low.
// The last sample of a set starts matching: first the stored samples are copied
// onto the feed line, then every treated sample is streamed as a query along
// the chain of cells (one per cycle), and a final step flags the end of the set.
// Busy stays high from the copy until that final step.
// Reset is synchronous and active low; it empties the store and the chain.
// The receiver cannot stall: each result is shown for exactly one cycle.
module propensity_nearest_match #(
    parameter int MAX_SAMPLES = 64,
    parameter int SCORE_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pnm_pkg::t_sample i_sample,
    output logic             o_strobe,
    output pnm_pkg::t_result o_result
);
    import pnm_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CYC_W = $clog2(2 * MAX_SAMPLES + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_COPY,
        S_RUN
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_drop;
    logic [CYC_W-1:0]  r_cyc;
    logic              r_have;
    t_result           r_hold;
    logic [IDX_W-1:0]  r_pairs;
    logic              r_strobe;
    t_result           r_result;

    logic              w_accept;
    logic [SCORE_BITS-1:0] w_score;
    logic [31:0]       w_score_ext;
    t_query            w_query [MAX_SAMPLES+1];
    t_feed             w_feed  [MAX_SAMPLES+1];
    t_query            w_tail;
    logic              w_inject;
    t_result           w_final;

    assign busy        = (r_state != S_LOAD);
    assign w_accept    = start && !busy;
    assign w_score_ext = {16'd0, i_sample.score};
    assign w_score     = w_score_ext[SCORE_BITS-1:0];

    // Queries enter at cell zero in load order, taken from the head of the feed.
    assign w_inject = (r_state == S_RUN) && (r_cyc < CYC_W'(MAX_SAMPLES)) &&
                      (r_cyc < CYC_W'(r_count)) && (w_feed[0].group == GRP_TREATED);

    always_comb begin
        w_query[0]               = '0;
        w_query[0].score         = w_feed[0].score;
        w_query[0].treated_index = IDX_W'(r_cyc);
        w_query[0].valid         = w_inject;
    end

    // The closing result of a set: the held pair with the end mark, or an
    // empty result when no treated sample found a control.
    always_comb begin
        w_final            = r_have ? r_hold : '0;
        w_final.end_of_run = 1'b1;
        w_final.overflow   = r_drop;
    end

    assign w_feed[MAX_SAMPLES] = '0;
    assign w_tail              = w_query[MAX_SAMPLES];

    for (genvar k = 0; k < MAX_SAMPLES; k++) begin : g_cell
        pnm_cell #(
            .SCORE_BITS (SCORE_BITS),
            .CNT_W      (CNT_W),
            .CELL_IDX   (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wr_en      (w_accept && (r_count == CNT_W'(k))),
            .i_wr_score   (w_score),
            .i_wr_group   (i_sample.group),
            .i_feed_load  (r_state == S_COPY),
            .i_feed_shift (r_state == S_RUN),
            .i_feed_next  (w_feed[k+1]),
            .o_feed       (w_feed[k]),
            .i_count      (r_count),
            .i_query      (w_query[k]),
            .o_query      (w_query[k+1])
        );
    end

    // Each finished pair is held back by one so that the last pair of the set
    // can carry the end mark once the chain has drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_cyc    <= '0;
            r_have   <= 1'b0;
            r_pairs  <= '0;
            r_strobe <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    r_strobe <= 1'b0;
                    if (w_accept) begin
                        if (r_count < CNT_W'(MAX_SAMPLES)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_sample.last_sample) begin
                            r_state <= S_COPY;
                        end
                    end
                end
                S_COPY: begin
                    r_strobe <= 1'b0;
                    r_cyc    <= '0;
                    r_have   <= 1'b0;
                    r_pairs  <= '0;
                    r_state  <= S_RUN;
                end
                S_RUN: begin
                    if (r_cyc == CYC_W'(2 * MAX_SAMPLES)) begin
                        r_strobe <= 1'b1;
                        r_result <= w_final;
                        r_count  <= '0;
                        r_drop   <= 1'b0;
                        r_have   <= 1'b0;
                        r_state  <= S_LOAD;
                    end else begin
                        r_cyc    <= r_cyc + 1'b1;
                        r_strobe <= w_tail.valid && w_tail.found && r_have;
                        if (w_tail.valid && w_tail.found) begin
                            if (r_have) begin
                                r_result <= r_hold;
                            end
                            r_hold.treated_index <= w_tail.treated_index;
                            r_hold.control_index <= w_tail.best_index;
                            r_hold.pair_valid    <= 1'b1;
                            r_hold.pair_count    <= r_pairs + 1'b1;
                            r_hold.end_of_run    <= 1'b0;
                            r_hold.overflow      <= r_drop;
                            r_pairs              <= r_pairs + 1'b1;
                            r_have               <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_LOAD;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
